@@ hdl/sha_pkg.sv @@
// Shared types, constants and message schedule functions for the SHA-256 stream hasher.
`timescale 1ns / 1ps
package sha_pkg;

    typedef enum logic [1:0] {
        OP_APPEND   = 2'd0,
        OP_FINALIZE = 2'd1,
        OP_RESET    = 2'd2,
        OP_UNUSED   = 2'd3
    } op_t;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] data_byte;
    } in_beat_t;

    typedef struct packed {
        logic        status;
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last;
    } out_beat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_ADD,
        ST_PAD_START,
        ST_PAD_LOAD,
        ST_PAD_ROUND,
        ST_PAD_ADD,
        ST_EMIT,
        ST_CONFLICT
    } state_t;

    typedef enum logic [1:0] {
        PAD_NONE  = 2'd0,
        PAD_DATA  = 2'd1,
        PAD_LEN   = 2'd2
    } pad_mode_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       store_byte;
        logic       clear_all;
        logic       load_work;
        logic       from_hash;
        logic       round;
        logic       add_hash;
        logic       add_temp;
        logic       save_digest;
        logic       pad_load;
        logic       pad_second;
        logic [5:0] round_idx;
        logic [3:0] load_idx;
    } dp_cmd_t;

    typedef struct packed {
        logic       block_full;
        logic       pad_two;
        logic       finalized;
    } dp_status_t;

    localparam logic [31:0] H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    localparam logic [31:0] K_ROUND [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] PAD_LIMIT = 6'd56;

    function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
        rotr = (v >> n) | (v << (32 - n));
    endfunction

    function automatic logic [31:0] sig0(input logic [31:0] x);
        sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] sig1(input logic [31:0] x);
        sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

@@ hdl/sha256_stream_hasher_unit.sv @@
// Top level of the SHA-256 stream hasher.
//
// Input beats carry an operation and a data byte; output beats carry status,
// one digest word, its index and a last flag. Both channels use valid/stall.
// An append beat stores its byte in the block buffer; the 64th byte of a block
// starts a compression that holds off input: byte loading through the block
// buffer memory, 64 rounds of the shared round unit and an add into the hash.
// A first finalize runs a set-up step, one or two padded blocks and a digest
// store, and then emits eight words, one per cycle while not stalled. A
// repeated finalize replays the stored digest from the next cycle. An append
// after a finalize gives one conflict beat in the next cycle. Input is taken
// again in the cycle after the last output beat. While the receiver stalls,
// the current output beat holds and no input is taken. Reset restores the
// initial hash words and clears the counters; the block buffer needs no
// clearing pass.
`timescale 1ns / 1ps
module sha256_stream_hasher_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  sha_pkg::in_beat_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output sha_pkg::out_beat_t out_data
);
    import sha_pkg::*;

    dp_cmd_t     cmd;
    dp_status_t  stat;
    logic [2:0]  emit_idx;
    logic [31:0] emit_word;
    logic        conflict;

    sha_controller u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_op        (in_data.operation),
        .in_stall     (in_stall),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_conflict (conflict),
        .emit_idx     (emit_idx),
        .stat         (stat),
        .cmd          (cmd)
    );

    sha_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .data_byte (in_data.data_byte),
        .cmd       (cmd),
        .emit_idx  (emit_idx),
        .stat      (stat),
        .emit_word (emit_word)
    );

    assign out_data.status = conflict;
    assign out_data.digest_word = conflict ? 32'd0 : emit_word;
    assign out_data.word_index = conflict ? 3'd0 : emit_idx;
    assign out_data.last = conflict || (emit_idx == 3'd7);
endmodule

@@ hdl/sha_ram.sv @@
// Generic simple dual-port RAM (one write port, one read port) with registered read.
`timescale 1ns / 1ps
module sha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ hdl/sha_datapath.sv @@
// Datapath: block buffer, message schedule, round registers and hash words.
`timescale 1ns / 1ps
module sha_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [7:0]          data_byte,
    input  sha_pkg::dp_cmd_t    cmd,
    input  logic [2:0]          emit_idx,
    output sha_pkg::dp_status_t stat,
    output logic [31:0]         emit_word
);
    import sha_pkg::*;

    logic [31:0] hash_reg [8];
    logic [31:0] hash_next [8];
    logic [31:0] dig_reg [8];
    logic [31:0] v_reg [8];
    logic [31:0] v_next [8];
    logic [31:0] tmp_reg [8];
    logic [31:0] w_reg [16];
    logic [31:0] w_next [16];
    logic [5:0]  fill_reg;
    logic [5:0]  fill_next;
    logic [63:0] bytes_reg;
    logic [63:0] bytes_next;
    logic        fin_reg;
    logic        fin_next;
    logic [7:0]  ram_rdata;
    logic [5:0]  ram_raddr;
    logic [31:0] wnew;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] pad_word;
    logic [63:0] bits;
    logic [5:0]  pos;

    sha_ram #(.WIDTH(8), .DEPTH(64)) u_buf (
        .clk   (clk),
        .we    (cmd.store_byte),
        .waddr (fill_reg),
        .wdata (data_byte),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Bytes are read one per cycle, one position ahead of the byte that lands.
    assign ram_raddr = cmd.load_work ? pos + 6'd1 : pos;
    assign bits = {bytes_reg[60:0], 3'b000};
    assign pos = {cmd.load_idx, cmd.round_idx[1:0]};

    always_comb
    begin
        pad_word = w_reg[15];
        if (cmd.pad_second || pos > fill_reg)
        begin
            pad_word = {w_reg[15][23:0], 8'h00};
        end
        else if (pos == fill_reg)
        begin
            pad_word = {w_reg[15][23:0], PAD_BYTE};
        end
        else
        begin
            pad_word = {w_reg[15][23:0], ram_rdata};
        end
        if (!cmd.pad_load)
        begin
            pad_word = {w_reg[15][23:0], ram_rdata};
        end
        else if (cmd.load_idx == 4'd14 && stat.pad_two == cmd.pad_second)
        begin
            pad_word = bits[63:32];
        end
        else if (cmd.load_idx == 4'd15 && stat.pad_two == cmd.pad_second)
        begin
            pad_word = bits[31:0];
        end
    end

    assign wnew = w_reg[0] + sig0(w_reg[1]) + w_reg[9] + sig1(w_reg[14]);
    assign t1 = v_reg[7] + (rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25))
              + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
              + K_ROUND[cmd.round_idx] + w_reg[0];
    assign t2 = (rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22))
              + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));

    always_comb
    begin
        v_next = v_reg;
        w_next = w_reg;
        hash_next = hash_reg;
        fill_next = fill_reg;
        bytes_next = bytes_reg;
        fin_next = fin_reg;
        if (cmd.load_work)
        begin
            w_next[15] = pad_word;
        end
        if (cmd.load_work && cmd.round_idx[1:0] == 2'd0)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_next[i] = w_reg[i + 1];
            end
            w_next[15] = pad_word;
        end
        if (cmd.from_hash)
        begin
            if (cmd.add_temp)
            begin
                v_next = tmp_reg;
            end
            else
            begin
                v_next = hash_reg;
            end
        end
        if (cmd.round)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_next[i] = w_reg[i + 1];
            end
            w_next[15] = wnew;
            v_next[7] = v_reg[6];
            v_next[6] = v_reg[5];
            v_next[5] = v_reg[4];
            v_next[4] = v_reg[3] + t1;
            v_next[3] = v_reg[2];
            v_next[2] = v_reg[1];
            v_next[1] = v_reg[0];
            v_next[0] = t1 + t2;
        end
        if (cmd.add_hash)
        begin
            for (int i = 0; i < 8; i++)
            begin
                hash_next[i] = hash_reg[i] + v_reg[i];
            end
        end
        if (cmd.store_byte)
        begin
            fill_next = fill_reg + 6'd1;
            bytes_next = bytes_reg + 64'd1;
        end
        if (cmd.save_digest)
        begin
            fin_next = 1'b1;
        end
        if (cmd.clear_all)
        begin
            hash_next = H_INIT;
            fill_next = '0;
            bytes_next = '0;
            fin_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg <= H_INIT;
            fill_reg <= '0;
            bytes_reg <= '0;
            fin_reg <= 1'b0;
        end
        else
        begin
            hash_reg <= hash_next;
            fill_reg <= fill_next;
            bytes_reg <= bytes_next;
            fin_reg <= fin_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg <= v_next;
        w_reg <= w_next;
        if (cmd.add_temp && !cmd.pad_load)
        begin
            for (int i = 0; i < 8; i++)
            begin
                tmp_reg[i] <= tmp_reg[i] + v_reg[i];
            end
        end
        else if (cmd.from_hash && cmd.pad_load && !cmd.add_temp)
        begin
            tmp_reg <= hash_reg;
        end
        if (cmd.save_digest)
        begin
            dig_reg <= tmp_reg;
        end
    end

    assign stat.block_full = (fill_reg == 6'd63);
    assign stat.pad_two = (fill_reg >= PAD_LIMIT) ? 1'b1 : 1'b0;
    assign stat.finalized = fin_reg;
    assign emit_word = dig_reg[emit_idx];
endmodule

@@ hdl/sha_controller.sv @@
// Controller: sequences loads, rounds, padding, digest emission and conflict beats.
`timescale 1ns / 1ps
module sha_controller (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [1:0]          in_op,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                out_conflict,
    output logic [2:0]          emit_idx,
    input  sha_pkg::dp_status_t stat,
    output sha_pkg::dp_cmd_t    cmd
);
    import sha_pkg::*;

    state_t     state_reg;
    state_t     state_next;
    logic [5:0] cnt_reg;
    logic [5:0] cnt_next;
    logic [3:0] wi_reg;
    logic [3:0] wi_next;
    logic       second_reg;
    logic       second_next;
    logic       accept;

    assign in_stall = (state_reg != ST_IDLE);
    assign accept = in_valid && !in_stall;
    assign emit_idx = cnt_reg[2:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg <= '0;
            wi_reg <= '0;
            second_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            wi_reg <= wi_next;
            second_reg <= second_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        wi_next = wi_reg;
        second_next = second_reg;
        cmd = '0;
        cmd.round_idx = cnt_reg;
        cmd.load_idx = wi_reg;
        cmd.pad_second = second_reg;
        out_valid = 1'b0;
        out_conflict = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                wi_next = '0;
                second_next = 1'b0;
                if (accept)
                begin
                    case (op_t'(in_op))
                        OP_APPEND:
                        begin
                            if (stat.finalized)
                            begin
                                state_next = ST_CONFLICT;
                            end
                            else
                            begin
                                cmd.store_byte = 1'b1;
                                if (stat.block_full)
                                begin
                                    state_next = ST_LOAD;
                                end
                            end
                        end
                        OP_FINALIZE:
                        begin
                            state_next = stat.finalized ? ST_EMIT : ST_PAD_START;
                        end
                        OP_RESET:
                        begin
                            cmd.clear_all = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_LOAD, ST_PAD_LOAD:
            begin
                // One byte a cycle: the first read is issued before data lands.
                cmd.pad_load = (state_reg == ST_PAD_LOAD);
                cmd.round_idx = {4'd0, cnt_reg[1:0]};
                cmd.load_idx = wi_reg;
                cmd.add_temp = (state_reg == ST_PAD_LOAD);
                if (cnt_reg[5])
                begin
                    cmd.load_work = 1'b1;
                    cmd.round_idx = {4'd0, cnt_reg[1:0] - 2'd1};
                    cmd.load_idx = (cnt_reg[1:0] == 2'd0) ? wi_reg - 4'd1 : wi_reg;
                end
                cnt_next = {1'b1, cnt_reg[4:0] + 5'd1};
                if (cnt_reg[5] && cnt_reg[1:0] == 2'd0)
                begin
                    cnt_next = {1'b1, 5'd1};
                end
                if (cnt_reg[1:0] == 2'd3)
                begin
                    wi_next = wi_reg + 4'd1;
                end
                if (cnt_reg[5] && cnt_reg[1:0] == 2'd0 && wi_reg == 4'd0)
                begin
                    cmd.from_hash = 1'b1;
                    cnt_next = '0;
                    state_next = (state_reg == ST_LOAD) ? ST_ROUND : ST_PAD_ROUND;
                end
            end
            ST_ROUND, ST_PAD_ROUND:
            begin
                cmd.round = 1'b1;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    state_next = (state_reg == ST_ROUND) ? ST_ADD : ST_PAD_ADD;
                end
            end
            ST_ADD:
            begin
                cmd.add_hash = 1'b1;
                state_next = ST_IDLE;
            end
            ST_PAD_START:
            begin
                cmd.from_hash = 1'b1;
                cmd.pad_load = 1'b1;
                cmd.add_temp = 1'b0;
                cnt_next = '0;
                wi_next = '0;
                state_next = ST_PAD_LOAD;
            end
            ST_PAD_ADD:
            begin
                cmd.add_temp = 1'b1;
                cnt_next = '0;
                wi_next = '0;
                if (stat.pad_two && !second_reg)
                begin
                    second_next = 1'b1;
                    state_next = ST_PAD_LOAD;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                cmd.save_digest = (cnt_reg == 6'd0) && !stat.finalized;
                cmd.pad_load = cmd.save_digest;
                out_valid = !cmd.save_digest;
                if (out_valid && !out_stall)
                begin
                    cnt_next = cnt_reg + 6'd1;
                    if (cnt_reg[2:0] == 3'd7)
                    begin
                        cnt_next = '0;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_CONFLICT:
            begin
                out_valid = 1'b1;
                out_conflict = 1'b1;
                if (!out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end
endmodule

@@ hdl/sha_checker.sv @@
// Port checker for the SHA-256 stream hasher, bound to the top level.
`timescale 1ns / 1ps
module sha_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input sha_pkg::out_beat_t out_data,
    input logic               out_valid,
    input logic               out_stall
);
    import sha_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled output beat changed");

    a_no_take: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input taken while output pending");

    a_conf: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status |-> out_data.last && out_data.digest_word == 32'd0)
        else $error("conflict beat malformed");

    a_seq: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !out_data.status && !out_data.last
        |=> out_valid && out_data.word_index == $past(out_data.word_index) + 3'd1)
        else $error("digest word order broken");
endmodule

bind sha256_stream_hasher_unit sha_checker u_chk (.*);
